@@ src/rampenv_pkg.sv @@
`default_nettype none
package rampenv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EXP_DEPTH_DEF = 256;
  localparam int TIME_FRAC     = 16;
  localparam int EXP_LIMIT     = 40;

  localparam logic [2:0] REG_RAMP_MODE      = 3'd0;
  localparam logic [2:0] REG_RISE_DELAY     = 3'd1;
  localparam logic [2:0] REG_RISE_DURATION  = 3'd2;
  localparam logic [2:0] REG_HOLD_DURATION  = 3'd3;
  localparam logic [2:0] REG_FALL_DURATION  = 3'd4;
  localparam logic [2:0] REG_DECAY_CONSTANT = 3'd5;
  localparam logic [2:0] REG_TIME_SCALE     = 3'd6;

  localparam logic [1:0] PH_OFF  = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_PLAT = 2'd2;
  localparam logic [1:0] PH_FALL = 2'd3;

  localparam logic MODE_LINEAR = 1'b0;

  // shift-subtract floor division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage
`default_nettype wire

@@ src/ramp_envelope_generator_top.sv @@
// Ramp envelope generator. Each sample_time is scaled by the Q16.16
// time_scale, placed in one of the off/rising/plateau/falling phases, and
// answered with an envelope factor (Q1.FRAC_BITS), its slope (Q2.30) and the
// phase. One item at a time: in_ready is high only while the sequencer idles.
// Work runs on one shared restoring divider and a few multipliers. Off and
// plateau need no divide; a linear ramp takes two divides; an exponential
// ramp takes up to two divides plus up to 39 exp(-1) multiply steps. A
// finished result waits in an output register, so the next item can be
// taken while it is unread.
`default_nettype none
module ramp_envelope_generator_top
  import rampenv_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [31:0]           sample_time,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FRAC_BITS:0]         envelope,
  output logic signed [31:0]         slope,
  output logic [1:0]                 phase,
  input  wire logic                  cfg_wr_en,
  input  wire logic [2:0]            cfg_addr,
  input  wire logic [31:0]           cfg_wdata
);

  localparam int DVW = 32 + FRAC_BITS;
  localparam int CW  = $clog2(DVW + 1);
  localparam int AW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int DPW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int WW  = $clog2(EXP_LIMIT);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef logic [32:0] tab_t [0:EXP_TABLE_DEPTH];

  function automatic tab_t build_tab();
    tab_t r;
    logic [63:0] y, term, pos, neg;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      y    = udiv64(64'(k) << 30, 64'(EXP_TABLE_DEPTH));
      term = 64'd1 << 32;
      pos  = term;
      neg  = '0;
      for (int n = 1; n < 24; n++) begin
        if (term != 0) begin
          term = udiv64((term * y) >> 30, 64'(n));
          if (n % 2 == 1) neg = neg + term;
          else pos = pos + term;
        end
      end
      r[k] = 33'(pos - neg);
    end
    return r;
  endfunction

  localparam tab_t EXP_TAB = build_tab();
  localparam logic [32:0] EXP_M1 = EXP_TAB[EXP_TABLE_DEPTH];

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_SCALE = 18'h00002,
    S_BND   = 18'h00004,
    S_PHASE = 18'h00008,
    S_DISP  = 18'h00010,
    S_DIV   = 18'h00020,
    S_LENV  = 18'h00040,
    S_LSLP  = 18'h00080,
    S_XQ    = 18'h00100,
    S_LKA   = 18'h00200,
    S_LKB   = 18'h00400,
    S_INTM  = 18'h00800,
    S_INTS  = 18'h01000,
    S_WHOLE = 18'h02000,
    S_EXPF  = 18'h04000,
    S_PE    = 18'h08000,
    S_XSLP  = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t state, dv_ret;

  // configuration
  logic        ramp_mode;
  logic [31:0] rise_delay, rise_duration, hold_duration, fall_duration;
  logic [31:0] decay_constant, time_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_mode      <= 1'b1;
      rise_delay     <= '0;
      rise_duration  <= '0;
      hold_duration  <= '0;
      fall_duration  <= '0;
      decay_constant <= '0;
      time_scale     <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RAMP_MODE:      ramp_mode      <= cfg_wdata[0];
        REG_RISE_DELAY:     rise_delay     <= cfg_wdata;
        REG_RISE_DURATION:  rise_duration  <= cfg_wdata;
        REG_HOLD_DURATION:  hold_duration  <= cfg_wdata;
        REG_FALL_DURATION:  fall_duration  <= cfg_wdata;
        REG_DECAY_CONSTANT: decay_constant <= cfg_wdata;
        REG_TIME_SCALE:     time_scale     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // datapath registers
  logic [31:0]            samp, t, d;
  logic [32:0]            th;
  logic [33:0]            td;
  logic [34:0]            tl;
  logic [37:0]            tau40;
  logic [1:0]             ph;
  logic [FRAC_BITS:0]     peak, res_env;
  logic [31:0]            res_slope;
  logic [WW-1:0]          wcnt;
  logic [DPW-1:0]         idx;
  logic [FRAC_BITS-1:0]   fr;
  logic [32:0]            ta, v;
  logic [32+FRAC_BITS:0]  mprod;
  logic [FRAC_BITS+33:0]  pe;

  // shared divider
  logic [DVW-1:0] dv_num, dv_q;
  logic [31:0]    dv_den, dv_rem;
  logic [CW-1:0]  dv_cnt;
  logic [32:0]    rem_sh;
  logic           rem_ge;

  assign rem_sh = {dv_rem, dv_num[DVW-1]};
  assign rem_ge = rem_sh >= {1'b0, dv_den};

  // table port
  logic [AW-1:0] rom_addr;
  logic [32:0]   rom_q;

  always_comb begin
    case (state)
      S_LKB:   rom_addr = AW'(idx) + AW'(1);
      default: rom_addr = AW'(idx);
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q <= EXP_TAB[rom_addr];
  end

  // combinational helpers
  logic [63:0]            sprod;
  logic                   in_rise, in_plat, in_fall;
  logic [FRAC_BITS+12:0]  fpos;
  logic [33:0]            rnd;
  logic [65:0]            vm;

  assign sprod   = samp * time_scale;
  assign in_rise = (rise_duration != 0) && ({3'b0, t} >= {3'b0, rise_delay}) &&
                   ({2'b0, t} < {1'b0, th});
  assign in_plat = (rise_duration != 0) && ({2'b0, t} >= {1'b0, th}) &&
                   ({2'b0, t} < td);
  assign in_fall = (fall_duration != 0) && ({2'b0, t} >= td) && ({3'b0, t} < tl);
  assign fpos    = (FRAC_BITS + 13)'(dv_q[FRAC_BITS-1:0]) *
                   (FRAC_BITS + 13)'(EXP_TABLE_DEPTH);
  assign rnd     = ({1'b0, v} + (34'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  assign vm      = v * EXP_M1;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dv_ret    <= S_IDLE;
      out_valid <= 1'b0;
      peak      <= '0;
      dv_cnt    <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            samp  <= sample_time;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          t     <= (sprod[63:48] != 0) ? 32'hFFFF_FFFF : sprod[47:16];
          th    <= {1'b0, rise_delay} + {1'b0, rise_duration};
          state <= S_BND;
        end
        S_BND: begin
          td    <= {1'b0, th} + {2'b0, hold_duration};
          tl    <= {2'b0, th} + {3'b0, hold_duration} + {3'b0, fall_duration};
          tau40 <= {1'b0, decay_constant, 5'b0} + {3'b0, decay_constant, 3'b0};
          state <= S_PHASE;
        end
        S_PHASE: begin
          if (in_rise) begin
            ph <= PH_RISE;
            d  <= t - rise_delay;
          end else if (in_plat) begin
            ph <= PH_PLAT;
            d  <= '0;
          end else if (in_fall) begin
            ph <= PH_FALL;
            d  <= t - td[31:0];
          end else begin
            ph <= PH_OFF;
            d  <= '0;
          end
          state <= S_DISP;
        end
        S_DISP: begin
          res_env   <= '0;
          res_slope <= '0;
          state     <= S_OUT;
          case (ph)
            PH_OFF: begin
              if (ramp_mode != MODE_LINEAR) peak <= '0;
            end
            PH_PLAT: begin
              res_env <= ONE;
              if (ramp_mode != MODE_LINEAR) peak <= ONE;
            end
            default: begin
              if (ramp_mode == MODE_LINEAR) begin
                dv_num <= {d, FRAC_BITS'(0)};
                dv_den <= (ph == PH_RISE) ? rise_duration : fall_duration;
                dv_rem <= '0;
                dv_cnt <= CW'(DVW);
                dv_ret <= S_LENV;
                state  <= S_DIV;
              end else if (decay_constant == 0) begin
                if (ph == PH_RISE) begin
                  res_env <= ONE;
                  peak    <= ONE;
                end
              end else if ({6'b0, d} >= tau40) begin
                v      <= '0;
                dv_den <= decay_constant;
                state  <= S_EXPF;
              end else begin
                dv_num <= {d, FRAC_BITS'(0)};
                dv_den <= decay_constant;
                dv_rem <= '0;
                dv_cnt <= CW'(DVW);
                dv_ret <= S_XQ;
                state  <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          dv_rem <= rem_ge ? 32'(rem_sh - {1'b0, dv_den}) : rem_sh[31:0];
          dv_q   <= {dv_q[DVW-2:0], rem_ge};
          dv_num <= dv_num << 1;
          dv_cnt <= dv_cnt - CW'(1);
          if (dv_cnt == CW'(1)) state <= dv_ret;
        end
        S_LENV: begin
          res_env <= (ph == PH_RISE) ? dv_q[FRAC_BITS:0] : ONE - dv_q[FRAC_BITS:0];
          dv_num  <= DVW'(1) << 30;
          dv_rem  <= '0;
          dv_cnt  <= CW'(DVW);
          dv_ret  <= S_LSLP;
          state   <= S_DIV;
        end
        S_LSLP: begin
          res_slope <= (ph == PH_RISE) ? dv_q[31:0] : 32'(-dv_q[31:0]);
          state     <= S_OUT;
        end
        S_XQ: begin
          wcnt  <= dv_q[FRAC_BITS+WW-1:FRAC_BITS];
          idx   <= DPW'(fpos >> FRAC_BITS);
          fr    <= fpos[FRAC_BITS-1:0];
          state <= S_LKA;
        end
        S_LKA: begin
          state <= S_LKB;
        end
        S_LKB: begin
          ta    <= rom_q;
          state <= S_INTM;
        end
        S_INTM: begin
          mprod <= (ta - rom_q) * fr;
          state <= S_INTS;
        end
        S_INTS: begin
          v     <= ta - 33'(mprod >> FRAC_BITS);
          state <= S_WHOLE;
        end
        S_WHOLE: begin
          if (wcnt == 0 || v == 0) begin
            state <= S_EXPF;
          end else begin
            v    <= vm[64:32];
            wcnt <= wcnt - WW'(1);
          end
        end
        S_EXPF: begin
          if (ph == PH_RISE) begin
            res_env <= ONE - rnd[FRAC_BITS:0];
            if (ONE != rnd[FRAC_BITS:0]) peak <= ONE - rnd[FRAC_BITS:0];
            dv_num <= DVW'(v >> 2);
            dv_rem <= '0;
            dv_cnt <= CW'(DVW);
            dv_ret <= S_XSLP;
            state  <= S_DIV;
          end else begin
            pe    <= peak * v;
            state <= S_PE;
          end
        end
        S_PE: begin
          res_env <= pe[FRAC_BITS+32:32];
          dv_num  <= DVW'(pe >> (FRAC_BITS + 2));
          dv_rem  <= '0;
          dv_cnt  <= CW'(DVW);
          dv_ret  <= S_XSLP;
          state   <= S_DIV;
        end
        S_XSLP: begin
          res_slope <= (ph == PH_RISE) ? dv_q[31:0] : 32'(-dv_q[31:0]);
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            envelope  <= res_env;
            slope     <= res_slope;
            phase     <= ph;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_SCALE)
    else $error("sequencer did not start on accepted beat");

  a_env_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> envelope <= ONE)
    else $error("envelope above one");

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_OFF |-> envelope == 0 && slope == 0)
    else $error("off phase with nonzero output");

  a_plat_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_PLAT |-> envelope == ONE && slope == 0)
    else $error("plateau output wrong");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dv_cnt != 0)
    else $error("divider running with zero count");

endmodule
`default_nettype wire
